FILE: hdl/cfe_pkg.sv
// shared constants and types for the command frame extractor
package cfe_pkg;

  localparam int unsigned BufferDepth = 64;
  localparam int unsigned HalfDepth   = BufferDepth / 2;
  localparam int unsigned AddrW       = $clog2(BufferDepth);
  localparam int unsigned CountW      = AddrW + 1;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned CfgW        = 7;
  localparam int unsigned CmpW        = (CountW > CfgW) ? CountW : CfgW;

  localparam logic [ByteW-1:0] CtrlMax     = 8'h1F;
  localparam logic [ByteW-1:0] Terminator  = 8'h3B;
  localparam logic [CfgW-1:0]  MaxLenReset = 7'd64;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ByteW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

endpackage

FILE: hdl/cfe_ram.sv
// simple dual-port ram, one write and one registered read port
module cfe_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/cfe_ctrl.sv
// frame sequencer: store update on input, frame readout into the output register
module cfe_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rx_valid_i,
  output logic                        rx_ready_o,
  input  logic [cfe_pkg::ByteW-1:0]   rx_byte_i,
  input  logic [cfe_pkg::CfgW-1:0]    max_len_i,
  output cfe_pkg::ram_req_t           ram_req_o,
  input  logic [cfe_pkg::ByteW-1:0]   ram_rdata_i,
  output logic                        frame_valid_o,
  input  logic                        frame_ready_i,
  output logic [cfe_pkg::ByteW-1:0]   frame_byte_o,
  output logic                        frame_last_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND
  } state_e;

  state_e                       state_q;
  logic [cfe_pkg::AddrW-1:0]    head_q;
  logic [cfe_pkg::CountW-1:0]   count_q;
  logic [cfe_pkg::AddrW-1:0]    base_q;
  logic [cfe_pkg::CountW-1:0]   len_q;
  logic [cfe_pkg::CountW-1:0]   idx_q;
  logic                         out_valid_q;
  logic [cfe_pkg::ByteW-1:0]    out_byte_q;
  logic                         out_last_q;

  logic                         rx_fire;
  logic                         is_ctrl;
  logic                         is_term;
  logic                         full;
  logic [cfe_pkg::AddrW-1:0]    head_eff;
  logic [cfe_pkg::CountW-1:0]   count_eff;
  logic [cfe_pkg::CountW-1:0]   count_new;
  logic                         emit_ok;
  logic                         out_free;
  logic                         at_end;

  always_comb begin
    rx_fire   = rx_valid_i && (state_q == S_IDLE);
    is_ctrl   = rx_byte_i <= cfe_pkg::CtrlMax;
    is_term   = rx_byte_i == cfe_pkg::Terminator;
    full      = count_q >= cfe_pkg::CountW'(cfe_pkg::BufferDepth);
    head_eff  = full ? head_q + cfe_pkg::AddrW'(cfe_pkg::HalfDepth) : head_q;
    count_eff = full ? count_q - cfe_pkg::CountW'(cfe_pkg::HalfDepth) : count_q;
    count_new = count_eff + cfe_pkg::CountW'(1);
    emit_ok   = cfe_pkg::CmpW'(count_new) <= cfe_pkg::CmpW'(max_len_i);
    out_free  = !out_valid_q || frame_ready_i;
    at_end    = idx_q == len_q;

    ram_req_o.we    = rx_fire && !is_ctrl;
    ram_req_o.waddr = head_eff + count_eff[cfe_pkg::AddrW-1:0];
    ram_req_o.wdata = rx_byte_i;
    ram_req_o.re    = (state_q == S_READ) || ((state_q == S_SEND) && out_free && !at_end);
    ram_req_o.raddr = base_q + idx_q[cfe_pkg::AddrW-1:0];
  end

  assign rx_ready_o    = state_q == S_IDLE;
  assign frame_valid_o = out_valid_q;
  assign frame_byte_o  = out_byte_q;
  assign frame_last_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      base_q      <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && frame_ready_i && (state_q != S_SEND)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (rx_fire && !is_ctrl) begin
            if (is_term) begin
              head_q  <= '0;
              count_q <= '0;
              if (emit_ok) begin
                base_q  <= head_eff;
                len_q   <= count_new;
                idx_q   <= '0;
                state_q <= S_READ;
              end
            end else begin
              head_q  <= head_eff;
              count_q <= count_new;
            end
          end
        end
        S_READ: begin
          idx_q   <= idx_q + cfe_pkg::CountW'(1);
          state_q <= S_SEND;
        end
        S_SEND: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= ram_rdata_i;
            out_last_q  <= at_end;
            if (at_end) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= idx_q + cfe_pkg::CountW'(1);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/command_frame_extractor_top.sv
// top level of the command frame extractor: config register, sequencer and byte store
//
//   channel  direction  signals                                   content
//   rx       in         rx_valid_i / rx_ready_o                   rx_byte_i
//   frame    out        frame_valid_o / frame_ready_i             frame_byte_o, frame_last_o
//   cfg      in         cfg_valid_i / cfg_ready_o                 max_frame_length_i
//
// a byte that ends no frame never stalls the rx side; the store is written in the accept cycle
// a ';' that releases a frame holds off the rx side until the last frame byte is loaded into
// the output register, set by the single read port of the byte store
// stalls on the frame side stretch the readout
// the output register lets the next request in while the last frame byte waits
// reset is asynchronous and active low; the store needs no clearing pass
module command_frame_extractor_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rx_valid_i,
  output logic                        rx_ready_o,
  input  logic [cfe_pkg::ByteW-1:0]   rx_byte_i,
  output logic                        frame_valid_o,
  input  logic                        frame_ready_i,
  output logic [cfe_pkg::ByteW-1:0]   frame_byte_o,
  output logic                        frame_last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cfe_pkg::CfgW-1:0]    max_frame_length_i
);

  logic [cfe_pkg::CfgW-1:0]  max_len_q;
  cfe_pkg::ram_req_t         ram_req;
  logic [cfe_pkg::ByteW-1:0] ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= cfe_pkg::MaxLenReset;
    end else if (cfg_valid_i) begin
      max_len_q <= max_frame_length_i;
    end
  end

  cfe_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_valid_i    (rx_valid_i),
    .rx_ready_o    (rx_ready_o),
    .rx_byte_i     (rx_byte_i),
    .max_len_i     (max_len_q),
    .ram_req_o     (ram_req),
    .ram_rdata_i   (ram_rdata),
    .frame_valid_o (frame_valid_o),
    .frame_ready_i (frame_ready_i),
    .frame_byte_o  (frame_byte_o),
    .frame_last_o  (frame_last_o)
  );

  cfe_ram #(
    .Depth (cfe_pkg::BufferDepth),
    .Width (cfe_pkg::ByteW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // a byte that ends no frame never stalls the rx side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_valid_i && rx_ready_o && (rx_byte_i != cfe_pkg::Terminator)) |=> rx_ready_o)
    else $error("rx stalled after a non-terminator byte");

  // no request is taken while a frame is still being read out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid_o && !frame_last_o) |-> !rx_ready_o)
    else $error("rx accepted in the middle of a frame");

  // a stalled frame byte holds its value until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid_o && !frame_ready_i) |=>
      (frame_valid_o && $stable(frame_byte_o) && $stable(frame_last_o)))
    else $error("frame output changed while stalled");

  // the store is not written while a frame is read out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.re |-> !ram_req.we)
    else $error("store written during readout");

endmodule
